// ===== rtl/dwed_pkg.sv =====
// Shared constants, register indexes and control types of the double-window event denoiser.
`default_nettype none

package dwed_pkg;

  localparam int DEF_WINDOW_DEPTH = 32;
  localparam int DEF_COORD_BITS   = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int THRESH_W = 7;
  localparam int RADIUS_W = 13;
  localparam int WLEN_W   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_RADIUS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MODE     = 2'd3;

  localparam logic [THRESH_W-1:0] RST_COUNT_THRESHOLD = 7'd2;
  localparam logic [RADIUS_W-1:0] RST_L1_RADIUS       = 13'd2;
  localparam logic [WLEN_W-1:0]   RST_WINDOW_LENGTH   = 6'd32;
  localparam logic                RST_DOUBLE_MODE     = 1'b1;

  typedef struct packed {
    logic clear;
    logic sig_shift;
    logic noi_shift;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dwed_cell.sv =====
// One cell of the window chain: a signal entry, a noise entry and one stage of the probe.
`default_nettype none

module dwed_cell import dwed_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int CNT_W      = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctl_t                    ctl,
  input  wire logic                    keep,
  input  wire logic [RADIUS_W-1:0]     radius,
  input  wire logic                    sig_vld_i,
  input  wire logic [2*COORD_BITS-1:0] sig_ent_i,
  input  wire logic                    noi_vld_i,
  input  wire logic [2*COORD_BITS-1:0] noi_ent_i,
  output logic                         sig_vld_o,
  output logic      [2*COORD_BITS-1:0] sig_ent_o,
  output logic                         noi_vld_o,
  output logic      [2*COORD_BITS-1:0] noi_ent_o,
  input  wire logic                    prb_vld_i,
  input  wire logic [COORD_BITS-1:0]   prb_x_i,
  input  wire logic [COORD_BITS-1:0]   prb_y_i,
  input  wire logic [CNT_W-1:0]        prb_cnt_i,
  output logic                         prb_vld_o,
  output logic      [COORD_BITS-1:0]   prb_x_o,
  output logic      [COORD_BITS-1:0]   prb_y_o,
  output logic      [CNT_W-1:0]        prb_cnt_o
);

  localparam int DIST_W = COORD_BITS + 1;
  localparam int CMP_W  = (DIST_W > RADIUS_W) ? DIST_W : RADIUS_W;

  logic                    sig_vld_r;
  logic [2*COORD_BITS-1:0] sig_ent_r;
  logic                    noi_vld_r;
  logic [2*COORD_BITS-1:0] noi_ent_r;
  logic                    prb_vld_r;
  logic [COORD_BITS-1:0]   prb_x_r;
  logic [COORD_BITS-1:0]   prb_y_r;
  logic [CNT_W-1:0]        prb_cnt_r;
  logic [CNT_W-1:0]        prb_cnt_nxt;
  logic                    sig_hit;
  logic                    noi_hit;

  function automatic logic near(input logic [2*COORD_BITS-1:0] ent,
                                input logic [COORD_BITS-1:0]   px,
                                input logic [COORD_BITS-1:0]   py,
                                input logic [RADIUS_W-1:0]     rad);
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIST_W-1:0]     l1_sum;
    ex     = ent[COORD_BITS-1:0];
    ey     = ent[2*COORD_BITS-1:COORD_BITS];
    dx     = (px > ex) ? (px - ex) : (ex - px);
    dy     = (py > ey) ? (py - ey) : (ey - py);
    l1_sum = {1'b0, dx} + {1'b0, dy};
    return CMP_W'(l1_sum) <= CMP_W'(rad);
  endfunction

  always_comb begin
    sig_hit     = sig_vld_r && near(sig_ent_r, prb_x_i, prb_y_i, radius);
    noi_hit     = noi_vld_r && near(noi_ent_r, prb_x_i, prb_y_i, radius);
    prb_cnt_nxt = prb_cnt_i + CNT_W'(sig_hit) + CNT_W'(noi_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_vld_r <= 1'b0;
      noi_vld_r <= 1'b0;
      prb_vld_r <= 1'b0;
    end else begin
      prb_vld_r <= prb_vld_i;
      if (ctl.clear) begin
        sig_vld_r <= 1'b0;
        noi_vld_r <= 1'b0;
      end else begin
        if (ctl.sig_shift) begin
          sig_vld_r <= sig_vld_i & keep;
        end
        if (ctl.noi_shift) begin
          noi_vld_r <= noi_vld_i & keep;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sig_shift) begin
      sig_ent_r <= sig_ent_i;
    end
    if (ctl.noi_shift) begin
      noi_ent_r <= noi_ent_i;
    end
    prb_x_r   <= prb_x_i;
    prb_y_r   <= prb_y_i;
    prb_cnt_r <= prb_cnt_nxt;
  end

  assign sig_vld_o = sig_vld_r;
  assign sig_ent_o = sig_ent_r;
  assign noi_vld_o = noi_vld_r;
  assign noi_ent_o = noi_ent_r;
  assign prb_vld_o = prb_vld_r;
  assign prb_x_o   = prb_x_r;
  assign prb_y_o   = prb_y_r;
  assign prb_cnt_o = prb_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/double_window_event_denoiser.sv =====
// Top level of the double-window event denoiser: config registers, control and the cell chain.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall   | in_pixel_x, in_pixel_y
//   out_    | output    | out_valid/out_stall | out_is_signal
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// Each beat passes through these steps in order: the probe walks the cell chain one cell
// a cycle, the count is latched, then the decide step shifts the chosen window.
// A new input beat is taken while the previous result still waits on out_stall.
// Reset empties both windows and loads the register defaults; cfg_ready stays high.
// Writing window_length empties both windows.
`default_nettype none

module double_window_event_denoiser import dwed_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_pixel_x,
  input  wire logic [COORD_BITS-1:0] in_pixel_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_is_signal,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW    = 2 * COORD_BITS;
  localparam int CNT_W = $clog2(2 * WINDOW_DEPTH + 1);
  localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
  localparam int LW2   = (WLEN_W > LEN_W) ? WLEN_W : LEN_W;
  localparam int CW    = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [THRESH_W-1:0] thresh_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [WLEN_W-1:0]   wlen_r;
  logic                dmode_r;

  logic [LEN_W-1:0] fill_r;
  logic [LEN_W-1:0] len_act;
  logic [LW2-1:0]   wlen_ext;

  logic [PW-1:0]    dec_ent_r;
  logic [CNT_W-1:0] dec_cnt_r;

  logic out_valid_r;
  logic out_sig_r;

  logic in_fire;
  logic cfg_fire;
  logic decide_fire;
  logic filling;
  logic pass;
  ctl_t ctl;

  logic                  sig_vld_c [0:WINDOW_DEPTH];
  logic [PW-1:0]         sig_ent_c [0:WINDOW_DEPTH];
  logic                  noi_vld_c [0:WINDOW_DEPTH];
  logic [PW-1:0]         noi_ent_c [0:WINDOW_DEPTH];
  logic                  prb_vld_c [0:WINDOW_DEPTH];
  logic [COORD_BITS-1:0] prb_x_c   [0:WINDOW_DEPTH];
  logic [COORD_BITS-1:0] prb_y_c   [0:WINDOW_DEPTH];
  logic [CNT_W-1:0]      prb_cnt_c [0:WINDOW_DEPTH];

  assign in_fire     = in_valid && !in_stall;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign decide_fire = (state_r == ST_DECIDE) && (!out_valid_r || !out_stall);

  always_comb begin
    wlen_ext = LW2'(wlen_r);
    if (wlen_r == '0) begin
      len_act = LEN_W'(1);
    end else if (wlen_ext > LW2'(WINDOW_DEPTH)) begin
      len_act = LEN_W'(WINDOW_DEPTH);
    end else begin
      len_act = LEN_W'(wlen_ext);
    end
  end

  always_comb begin
    filling       = fill_r < len_act;
    pass          = CW'(dec_cnt_r) >= CW'(thresh_r);
    ctl.clear     = cfg_fire && (cfg_index == REG_WINDOW_LENGTH);
    ctl.sig_shift = decide_fire && (filling || pass);
    ctl.noi_shift = decide_fire && !filling && !pass && dmode_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (prb_vld_c[WINDOW_DEPTH]) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (decide_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thresh_r    <= RST_COUNT_THRESHOLD;
      radius_r    <= RST_L1_RADIUS;
      wlen_r      <= RST_WINDOW_LENGTH;
      dmode_r     <= RST_DOUBLE_MODE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          REG_COUNT_THRESHOLD: thresh_r <= cfg_wdata[THRESH_W-1:0];
          REG_L1_RADIUS:       radius_r <= cfg_wdata[RADIUS_W-1:0];
          REG_WINDOW_LENGTH:   wlen_r   <= cfg_wdata[WLEN_W-1:0];
          REG_DOUBLE_MODE:     dmode_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (ctl.clear) begin
        fill_r <= '0;
      end else if (decide_fire && filling) begin
        fill_r <= fill_r + LEN_W'(1);
      end
      if (decide_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && prb_vld_c[WINDOW_DEPTH]) begin
      dec_ent_r <= {prb_y_c[WINDOW_DEPTH], prb_x_c[WINDOW_DEPTH]};
      dec_cnt_r <= prb_cnt_c[WINDOW_DEPTH];
    end
    if (decide_fire) begin
      out_sig_r <= !filling && pass;
    end
  end

  assign sig_vld_c[0] = 1'b1;
  assign sig_ent_c[0] = dec_ent_r;
  assign noi_vld_c[0] = 1'b1;
  assign noi_ent_c[0] = dec_ent_r;
  assign prb_vld_c[0] = in_fire;
  assign prb_x_c[0]   = in_pixel_x;
  assign prb_y_c[0]   = in_pixel_y;
  assign prb_cnt_c[0] = '0;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic keep;
    assign keep = LW2'(i) < LW2'(len_act);

    dwed_cell #(
      .COORD_BITS(COORD_BITS),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .keep     (keep),
      .radius   (radius_r),
      .sig_vld_i(sig_vld_c[i]),
      .sig_ent_i(sig_ent_c[i]),
      .noi_vld_i(noi_vld_c[i]),
      .noi_ent_i(noi_ent_c[i]),
      .sig_vld_o(sig_vld_c[i+1]),
      .sig_ent_o(sig_ent_c[i+1]),
      .noi_vld_o(noi_vld_c[i+1]),
      .noi_ent_o(noi_ent_c[i+1]),
      .prb_vld_i(prb_vld_c[i]),
      .prb_x_i  (prb_x_c[i]),
      .prb_y_i  (prb_y_c[i]),
      .prb_cnt_i(prb_cnt_c[i]),
      .prb_vld_o(prb_vld_c[i+1]),
      .prb_x_o  (prb_x_c[i+1]),
      .prb_y_o  (prb_y_c[i+1]),
      .prb_cnt_o(prb_cnt_c[i+1])
    );
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_is_signal = out_sig_r;
  assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the double-window event denoiser: random and directed events.
`timescale 1ns / 100ps

module tb import dwed_pkg::*;;

  localparam int WD = DEF_WINDOW_DEPTH;
  localparam int CB = DEF_COORD_BITS;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CB-1:0]         in_pixel_x = '0;
  logic [CB-1:0]         in_pixel_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_is_signal;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  double_window_event_denoiser DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_signal(out_is_signal),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // Predictor state
  logic [THRESH_W-1:0] thr;
  logic [RADIUS_W-1:0] radius;
  logic [WLEN_W-1:0]   win_len;
  logic                dbl_mode;
  logic [2*CB-1:0]     sig_win [WD];
  logic [2*CB-1:0]     noi_win [WD];
  bit                  sig_vld [WD];
  bit                  noi_vld [WD];
  int                  sig_wr, sig_fill, noi_wr;

  pix_t pending_q [$];
  logic verdict_q [$];

  int send_idle_pct = 34;
  int recv_idle_pct = 68;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int events_sent = 0;
  int verdicts_seen = 0;
  int signal_seen = 0;
  int cfg_writes = 0;
  int settings = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("timeout: %0d verdicts outstanding", verdict_q.size());
    $display("status: fail");
    $finish;
  end

  function automatic void clear_windows();
    for (int i = 0; i < WD; i++) begin
      sig_vld[i] = 1'b0;
      noi_vld[i] = 1'b0;
    end
    sig_wr = 0;
    sig_fill = 0;
    noi_wr = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COUNT_THRESHOLD: thr = val[THRESH_W-1:0];
      REG_L1_RADIUS:       radius = val[RADIUS_W-1:0];
      REG_WINDOW_LENGTH: begin
        win_len = val[WLEN_W-1:0];
        clear_windows();
      end
      REG_DOUBLE_MODE:     dbl_mode = val[0];
      default: ;
    endcase
  endfunction

  function automatic int l1_dist(input logic [2*CB-1:0] e, input logic [CB-1:0] px,
                                 input logic [CB-1:0] py);
    int ex, ey, dx, dy;
    ex = int'(e[CB-1:0]);
    ey = int'(e[2*CB-1:CB]);
    dx = (ex > int'(px)) ? ex - int'(px) : int'(px) - ex;
    dy = (ey > int'(py)) ? ey - int'(py) : int'(py) - ey;
    return dx + dy;
  endfunction

  function automatic logic classify_event(input logic [CB-1:0] px, input logic [CB-1:0] py);
    int len, hits;
    logic [2*CB-1:0] xy_word;
    xy_word = {py, px};
    len = (win_len == 0) ? 1 : (int'(win_len) > WD) ? WD : int'(win_len);
    if (sig_wr >= len) sig_wr = 0;
    if (noi_wr >= len) noi_wr = 0;
    if (sig_fill < len) begin
      sig_win[sig_wr] = xy_word;
      sig_vld[sig_wr] = 1'b1;
      sig_wr = (sig_wr + 1 >= len) ? 0 : sig_wr + 1;
      sig_fill++;
      return 1'b0;
    end
    hits = 0;
    for (int i = 0; i < WD; i++) begin
      if (sig_vld[i] && l1_dist(sig_win[i], px, py) <= int'(radius)) hits++;
      if (noi_vld[i] && l1_dist(noi_win[i], px, py) <= int'(radius)) hits++;
    end
    if (hits >= int'(thr)) begin
      sig_win[sig_wr] = xy_word;
      sig_vld[sig_wr] = 1'b1;
      sig_wr = (sig_wr + 1 >= len) ? 0 : sig_wr + 1;
      return 1'b1;
    end
    if (dbl_mode) begin
      noi_win[noi_wr] = xy_word;
      noi_vld[noi_wr] = 1'b1;
      noi_wr = (noi_wr + 1 >= len) ? 0 : noi_wr + 1;
    end
    return 1'b0;
  endfunction

  // Driver: hold a stalled beat, otherwise offer the next pending event
  always @(posedge clk) begin : drive
    pix_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q = {verdict_q, classify_event(in_pixel_x, in_pixel_y)};
        events_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid <= 1'b1;
          in_pixel_x <= nxt.x;
          in_pixel_y <= nxt.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted verdict against the oldest prediction
  always @(posedge clk) begin : watch
    logic want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (out_is_signal === 1'b1) signal_seen++;
        if (verdict_q.size() == 0) begin
          if (errors < 10) $display("unexpected verdict %b at %0t", out_is_signal, $realtime);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_is_signal !== want) begin
            if (errors < 10)
              $display("verdict %0d: expected is_signal %b, got %b", verdicts_seen, want,
                       out_is_signal);
            errors++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic push_pix(input int px, input int py);
    pix_t p;
    p.x = px[CB-1:0];
    p.y = py[CB-1:0];
    pending_q = {pending_q, p};
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    settings++;
  endtask

  initial begin : stimulus
    int n_items, spread, pick, vx, vy;
    int cx [3];
    int cy [3];
    logic [CFG_DATA_W-1:0] val;

    thr = RST_COUNT_THRESHOLD;
    radius = RST_L1_RADIUS;
    win_len = RST_WINDOW_LENGTH;
    dbl_mode = RST_DOUBLE_MODE;
    clear_windows();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Tiny windows, exact matches only, corners of the sensor
    write_reg(REG_COUNT_THRESHOLD, 13'd1);
    write_reg(REG_L1_RADIUS, 13'd0);
    write_reg(REG_WINDOW_LENGTH, 13'd2);
    push_pix(0, 0);
    push_pix(4095, 4095);
    push_pix(0, 0);
    push_pix(4095, 4095);
    push_pix(4095, 0);
    push_pix(4095, 0);
    push_pix(0, 4095);
    push_pix(1, 0);
    wait_idle();

    // Zero threshold, radius covering the whole sensor, length zero
    write_reg(REG_L1_RADIUS, 13'd8190);
    write_reg(REG_WINDOW_LENGTH, 13'd0);
    write_reg(REG_COUNT_THRESHOLD, 13'd0);
    push_pix(2048, 2048);
    push_pix(0, 4095);
    push_pix(4095, 0);
    wait_idle();

    // Single mode from a clean start
    write_reg(REG_DOUBLE_MODE, 13'd0);
    write_reg(REG_COUNT_THRESHOLD, 13'd2);
    write_reg(REG_L1_RADIUS, 13'd8191);
    write_reg(REG_WINDOW_LENGTH, 13'd1);
    push_pix(5, 5);
    push_pix(6, 6);
    push_pix(7, 7);
    wait_idle();

    // Switch to single mode with a populated noise window
    write_reg(REG_DOUBLE_MODE, 13'd1);
    write_reg(REG_WINDOW_LENGTH, 13'd1);
    push_pix(10, 10);
    push_pix(20, 20);
    wait_idle();
    write_reg(REG_DOUBLE_MODE, 13'd0);
    push_pix(30, 30);
    push_pix(40, 40);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 34 : (ph < 8) ? 68 : 0;
      recv_idle_pct = (ph < 4) ? 68 : (ph < 8) ? 34 : 0;

      if (ph == 1) val = 13'd64;
      else if ($urandom_range(9) == 0) val = 13'd0;
      else if ($urandom_range(9) == 0) val = CFG_DATA_W'($urandom_range(5, 127));
      else val = CFG_DATA_W'($urandom_range(1, 4));
      write_reg(REG_COUNT_THRESHOLD, val);

      if (ph == 2) val = 13'd8190;
      else if ($urandom_range(9) == 0) val = CFG_DATA_W'($urandom_range(0, 8191));
      else val = CFG_DATA_W'($urandom_range(0, 12));
      write_reg(REG_L1_RADIUS, val);
      spread = (val > 6) ? 6 : int'(val) + 1;

      if (ph == 0 || ph == 3 || ph == 4 || ph == 8 || $urandom_range(1) == 0) begin
        if (ph == 0 || ph == 8) val = 13'd32;
        else if (ph == 3) val = 13'd63;
        else if (ph == 4) val = 13'd1;
        else if ($urandom_range(9) == 0) val = CFG_DATA_W'($urandom_range(0, 63));
        else val = CFG_DATA_W'($urandom_range(1, 8));
        write_reg(REG_WINDOW_LENGTH, val);
      end

      write_reg(REG_DOUBLE_MODE, CFG_DATA_W'($urandom_range(1)));

      if (ph == 1 || ph == 9) hold_req <= ~hold_req;

      for (int c = 0; c < 3; c++) begin
        cx[c] = $urandom_range(0, 4095);
        cy[c] = $urandom_range(0, 4095);
      end
      n_items = 50 + $urandom_range(0, 10);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(3) == 0) begin
          vx = $urandom_range(0, 4095);
          vy = $urandom_range(0, 4095);
        end else begin
          pick = $urandom_range(0, 2);
          vx = cx[pick] + int'($urandom_range(0, 2 * spread)) - spread;
          vy = cy[pick] + int'($urandom_range(0, 2 * spread)) - spread;
          if (vx < 0) vx = 0;
          if (vx > 4095) vx = 4095;
          if (vy < 0) vy = 0;
          if (vy > 4095) vy = 4095;
        end
        push_pix(vx, vy);
      end
      wait_idle();
    end

    repeat (WD + 4) @(posedge clk);
    if (verdict_q.size() != 0) errors += verdict_q.size();

    $display("covered %0d events over %0d register settings (%0d writes)", events_sent,
             settings, cfg_writes);
    $display("checked %0d verdicts, %0d kept as signal, %0d failures", verdicts_seen,
             signal_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
